>>> hw/rtl/pth_sensor_compensation_defines.svh
// Assertion macros for the sensor compensation block.
// Expects clk and rst in scope at the point of use; no other dependencies.
`ifndef PTH_SENSOR_COMPENSATION_DEFINES_SVH
`define PTH_SENSOR_COMPENSATION_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define PTHC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pth_sensor_compensation: implication check failed");

// Condition that must never be seen outside reset.
`define PTHC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("pth_sensor_compensation: forbidden condition seen");

`endif

>>> hw/rtl/pthc_pkg.sv
// Shared types, constants and helpers for the sensor compensation block.
// No dependencies.
package pthc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_CAL_TEMP       = 3'd0;
  localparam logic [2:0] REG_CAL_PRESS_LOW  = 3'd1;
  localparam logic [2:0] REG_CAL_PRESS_HIGH = 3'd2;
  localparam logic [2:0] REG_CAL_MIXED      = 3'd3;
  localparam logic [2:0] REG_CAL_HUM        = 3'd4;

  // Pipeline depths.
  localparam int FRONT_STAGES = 14;
  localparam int DIV_STAGES   = 32;
  localparam int BACK_STAGES  = 3;
  localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

  // Arithmetic constants of the compensation.
  localparam logic signed [31:0] P_OFFSET    = 32'sd64000;
  localparam logic signed [31:0] P_FULLSCALE = 32'sd1048576;
  localparam logic signed [31:0] P_SCALE     = 32'sd3125;
  localparam logic signed [31:0] P_ONE       = 32'sd32768;
  localparam logic signed [31:0] T_ROUND     = 32'sd128;
  localparam logic signed [31:0] H_OFFSET    = 32'sd76800;
  localparam logic signed [31:0] H_ROUND_A   = 32'sd16384;
  localparam logic signed [31:0] H_ONE_C     = 32'sd32768;
  localparam logic signed [31:0] H_ONE_E     = 32'sd2097152;
  localparam logic signed [31:0] H_ROUND_F   = 32'sd8192;
  localparam logic signed [31:0] H_MAX       = 32'sd419430400;

  // Unpacked calibration coefficients, each widened to 32 bits.
  typedef struct packed {
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    logic signed [31:0] t3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic signed [31:0] p3;
    logic signed [31:0] p4;
    logic signed [31:0] p5;
    logic signed [31:0] p6;
    logic signed [31:0] p7;
    logic signed [31:0] p8;
    logic signed [31:0] p9;
    logic signed [31:0] h1;
    logic signed [31:0] h2;
    logic signed [31:0] h3;
    logic signed [31:0] h4;
    logic signed [31:0] h5;
    logic signed [31:0] h6;
  } coef_t;

  // Results that travel alongside the pressure division.
  typedef struct packed {
    logic signed [31:0] temp;
    logic [16:0]        hum;
    logic               inv;
    logic               dbl;
  } side_t;

  function automatic logic signed [31:0] sext16(input logic [15:0] v);
    return $signed({{16{v[15]}}, v});
  endfunction

  function automatic logic signed [31:0] sext8(input logic [7:0] v);
    return $signed({{24{v[7]}}, v});
  endfunction

  function automatic logic signed [31:0] zext16(input logic [15:0] v);
    return $signed({16'b0, v});
  endfunction

  function automatic logic signed [31:0] zext8(input logic [7:0] v);
    return $signed({24'b0, v});
  endfunction

endpackage

>>> hw/rtl/pthc_front.sv
// Front pipeline: temperature, pressure numerator and divisor, and humidity.
// Depends on pthc_pkg.
module pthc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [19:0]          raw_p,
  input  logic [19:0]          raw_t,
  input  logic [15:0]          raw_h,
  input  pthc_pkg::coef_t      c,
  output logic                 out_valid,
  output logic [31:0]          dividend,
  output logic [31:0]          divisor,
  output pthc_pkg::side_t      side
);

  logic [14:1] v;

  logic signed [31:0] s1_a1, s1_d;
  logic [19:0]        s1_adcp, s2_adcp, s3_adcp, s4_adcp, s5_adcp, s6_adcp, s7_adcp;
  logic [19:0]        s8_adcp, s9_adcp;
  logic [15:0]        s1_adch, s2_adch, s3_adch, s4_adch, s5_adch, s6_adch;
  logic signed [31:0] s2_m1, s2_dd;
  logic signed [31:0] s3_v1t, s3_m2;
  logic signed [31:0] s4_tf;
  logic signed [31:0] s5_temp, s5_pv1, s5_hx;
  logic signed [31:0] s6_temp, s6_sq, s6_mp5, s6_mp2, s6_h5x, s6_b0, s6_c0;
  logic signed [31:0] s7_temp, s7_v2a, s7_p3m, s7_mp5, s7_mp2, s7_ha, s7_hb, s7_hc;
  logic signed [31:0] s8_temp, s8_pv2, s8_pv1, s8_bc, s8_ha;
  logic signed [31:0] s9_temp, s9_v1c, s9_em, s9_pv2, s9_ha;
  logic signed [31:0] s10_temp, s10_den, s10_np, s10_hf, s10_ha;
  logic signed [31:0] s11_temp, s11_den, s11_pm, s11_hx2;
  logic signed [31:0] s12_temp, s12_den, s12_sqh, s12_hx2;
  logic [31:0]        s12_dvd, s13_dvd, s14_dvd;
  logic               s12_dbl, s13_dbl, s14_dbl;
  logic signed [31:0] s13_temp, s13_den, s13_hm, s13_hx2;
  logic signed [31:0] s14_temp, s14_den;
  logic [16:0]        s14_hum;
  logic signed [31:0] hum_x, hum_clamped, hs;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[13:1], in_valid};
    end
  end

  // Stages 1 to 5: fine temperature and the values derived from it.
  always_ff @(posedge clk) begin
    s1_a1   <= $signed({15'b0, raw_t[19:3]}) - (c.t1 <<< 1);
    s1_d    <= $signed({16'b0, raw_t[19:4]}) - c.t1;
    s1_adcp <= raw_p;
    s1_adch <= raw_h;

    s2_m1   <= s1_a1 * c.t2;
    s2_dd   <= s1_d * s1_d;
    s2_adcp <= s1_adcp;
    s2_adch <= s1_adch;

    s3_v1t  <= s2_m1 >>> 11;
    s3_m2   <= (s2_dd >>> 12) * c.t3;
    s3_adcp <= s2_adcp;
    s3_adch <= s2_adch;

    s4_tf   <= s3_v1t + (s3_m2 >>> 14);
    s4_adcp <= s3_adcp;
    s4_adch <= s3_adch;

    s5_temp <= (s4_tf * 32'sd5 + pthc_pkg::T_ROUND) >>> 8;
    s5_pv1  <= (s4_tf >>> 1) - pthc_pkg::P_OFFSET;
    s5_hx   <= s4_tf - pthc_pkg::H_OFFSET;
    s5_adcp <= s4_adcp;
    s5_adch <= s4_adch;
  end

  // Stages 6 to 10: pressure divisor and numerator, humidity factors.
  always_ff @(posedge clk) begin
    s6_temp <= s5_temp;
    s6_sq   <= (s5_pv1 >>> 2) * (s5_pv1 >>> 2);
    s6_mp5  <= s5_pv1 * c.p5;
    s6_mp2  <= c.p2 * s5_pv1;
    s6_h5x  <= c.h5 * s5_hx;
    s6_b0   <= s5_hx * c.h6;
    s6_c0   <= s5_hx * c.h3;
    s6_adcp <= s5_adcp;
    s6_adch <= s5_adch;

    s7_temp <= s6_temp;
    s7_v2a  <= (s6_sq >>> 11) * c.p6;
    s7_p3m  <= c.p3 * (s6_sq >>> 13);
    s7_mp5  <= s6_mp5;
    s7_mp2  <= s6_mp2;
    s7_ha   <= (($signed({16'b0, s6_adch}) <<< 14) - (c.h4 <<< 20) - s6_h5x
                + pthc_pkg::H_ROUND_A) >>> 15;
    s7_hb   <= s6_b0 >>> 10;
    s7_hc   <= (s6_c0 >>> 11) + pthc_pkg::H_ONE_C;
    s7_adcp <= s6_adcp;

    s8_temp <= s7_temp;
    s8_pv2  <= ((s7_v2a + (s7_mp5 <<< 1)) >>> 2) + (c.p4 <<< 16);
    s8_pv1  <= ((s7_p3m >>> 3) + (s7_mp2 >>> 1)) >>> 18;
    s8_bc   <= s7_hb * s7_hc;
    s8_ha   <= s7_ha;
    s8_adcp <= s7_adcp;

    s9_temp <= s8_temp;
    s9_v1c  <= (pthc_pkg::P_ONE + s8_pv1) * c.p1;
    s9_em   <= ((s8_bc >>> 10) + pthc_pkg::H_ONE_E) * c.h2;
    s9_pv2  <= s8_pv2;
    s9_ha   <= s8_ha;
    s9_adcp <= s8_adcp;

    s10_temp <= s9_temp;
    s10_den  <= s9_v1c >>> 15;
    s10_np   <= (pthc_pkg::P_FULLSCALE - $signed({12'b0, s9_adcp})) - (s9_pv2 >>> 12);
    s10_hf   <= (s9_em + pthc_pkg::H_ROUND_F) >>> 14;
    s10_ha   <= s9_ha;
  end

  // Humidity correction term and clamp.
  always_comb begin
    hs          = s11_hx2 >>> 15;
    hum_x       = s13_hx2 - (s13_hm >>> 4);
    hum_clamped = hum_x;
    if (hum_x[31]) begin
      hum_clamped = '0;
    end else if (hum_x > pthc_pkg::H_MAX) begin
      hum_clamped = pthc_pkg::H_MAX;
    end
  end

  // Stages 11 to 14: scaled numerator, division operand, humidity finish.
  always_ff @(posedge clk) begin
    s11_temp <= s10_temp;
    s11_den  <= s10_den;
    s11_pm   <= s10_np * pthc_pkg::P_SCALE;
    s11_hx2  <= s10_ha * s10_hf;

    s12_temp <= s11_temp;
    s12_den  <= s11_den;
    s12_dbl  <= s11_pm[31];
    s12_dvd  <= s11_pm[31] ? s11_pm : {s11_pm[30:0], 1'b0};
    s12_sqh  <= hs * hs;
    s12_hx2  <= s11_hx2;

    s13_temp <= s12_temp;
    s13_den  <= s12_den;
    s13_dbl  <= s12_dbl;
    s13_dvd  <= s12_dvd;
    s13_hm   <= (s12_sqh >>> 7) * c.h1;
    s13_hx2  <= s12_hx2;

    s14_temp <= s13_temp;
    s14_den  <= s13_den;
    s14_dbl  <= s13_dbl;
    s14_dvd  <= s13_dvd;
    s14_hum  <= hum_clamped[28:12];
  end

  assign out_valid = v[14];
  assign dividend  = s14_dvd;
  assign divisor   = s14_den;
  assign side.temp = s14_temp;
  assign side.hum  = s14_hum;
  assign side.inv  = (s14_den == '0);
  assign side.dbl  = s14_dbl;

endmodule

>>> hw/rtl/pthc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side band.
// Depends on pthc_pkg.
module pthc_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [31:0]     dividend,
  input  logic [31:0]     divisor,
  input  pthc_pkg::side_t in_side,
  output logic            out_valid,
  output logic [31:0]     quotient,
  output pthc_pkg::side_t out_side
);

  localparam int N = pthc_pkg::DIV_STAGES;

  logic [N-1:0]    vld;
  logic [31:0]     rem_q [N];
  logic [31:0]     dq_q  [N];
  logic [31:0]     den_q [N];
  pthc_pkg::side_t side_q [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic            v_in;
    logic [31:0]     rem_in, dq_in, den_in;
    pthc_pkg::side_t side_in;
    logic [32:0]     rem_sh;
    logic [33:0]     diff;

    if (g == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign dq_in   = dividend;
      assign den_in  = divisor;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = vld[g-1];
      assign rem_in  = rem_q[g-1];
      assign dq_in   = dq_q[g-1];
      assign den_in  = den_q[g-1];
      assign side_in = side_q[g-1];
    end

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb begin
      rem_sh = {rem_in, dq_in[31]};
      diff   = {1'b0, rem_sh} - {2'b0, den_in};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[g]  <= diff[33] ? rem_sh[31:0] : diff[31:0];
      dq_q[g]   <= {dq_in[30:0], ~diff[33]};
      den_q[g]  <= den_in;
      side_q[g] <= side_in;
    end
  end

  assign out_valid = vld[N-1];
  assign quotient  = dq_q[N-1];
  assign out_side  = side_q[N-1];

endmodule

>>> hw/rtl/pthc_back.sv
// Back pipeline: second-order pressure correction and the output register.
// Depends on pthc_pkg.
module pthc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [31:0]         quotient,
  input  pthc_pkg::side_t     in_side,
  input  pthc_pkg::coef_t     c,
  output logic                done,
  output logic signed [31:0]  temperature_centi,
  output logic [31:0]         pressure_pa,
  output logic [16:0]         humidity_q10,
  output logic                pressure_invalid
);

  logic [2:0]         v;
  logic [31:0]        p_sel, a_p, b_p;
  logic [28:0]        p_s3;
  logic [31:0]        a_mq;
  logic signed [31:0] a_m8, b_m8, b_mp9;
  pthc_pkg::side_t    a_side, b_side;
  logic signed [31:0] corr;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[1:0], in_valid};
    end
  end

  // Undo the halving used to keep the numerator in range.
  always_comb begin
    p_sel = in_side.dbl ? {quotient[30:0], 1'b0} : quotient;
    p_s3  = p_sel[31:3];
  end

  always_ff @(posedge clk) begin
    a_p    <= p_sel;
    a_mq   <= {3'b0, p_s3} * {3'b0, p_s3};
    a_m8   <= $signed({2'b0, p_sel[31:2]}) * c.p8;
    a_side <= in_side;

    b_p    <= a_p;
    b_mp9  <= c.p9 * $signed({13'b0, a_mq[31:13]});
    b_m8   <= a_m8;
    b_side <= a_side;
  end

  always_comb begin
    corr = ((b_mp9 >>> 12) + (b_m8 >>> 13) + c.p7) >>> 4;
  end

  // Output register; a zero divisor forces the pressure to zero.
  always_ff @(posedge clk) begin
    temperature_centi <= b_side.temp;
    humidity_q10      <= b_side.hum;
    pressure_invalid  <= b_side.inv;
    pressure_pa       <= b_side.inv ? '0 : (b_p + $unsigned(corr));
  end

  assign done = v[2];

endmodule

>>> hw/rtl/pth_sensor_compensation.sv
// Pressure, temperature and humidity compensation, top level.
// Each start transaction passes the front, divider and back pipelines to the done strobe.
// Throughput: one transaction per cycle; busy is always low and results cannot be held off.
// The 32-stage divider pipeline for the pressure quotient sets most of the latency.
// Synchronous reset clears all valid bits and calibration registers; depends on pthc_pkg.
`include "pth_sensor_compensation_defines.svh"

module pth_sensor_compensation (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        raw_pressure,
  input  logic [19:0]        raw_temperature,
  input  logic [15:0]        raw_humidity,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [63:0]        wr_data,
  output logic               done,
  output logic signed [31:0] temperature_centi,
  output logic [31:0]        pressure_pa,
  output logic [16:0]        humidity_q10,
  output logic               pressure_invalid
);

  logic [47:0]     cal_temp;
  logic [63:0]     cal_press_low;
  logic [63:0]     cal_press_high;
  logic [47:0]     cal_mixed;
  logic [39:0]     cal_hum;
  pthc_pkg::coef_t coef;

  logic            f_valid, d_valid;
  logic [31:0]     f_dvd, f_den, d_quo;
  pthc_pkg::side_t f_side, d_side;
  logic            accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Calibration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp       <= '0;
      cal_press_low  <= '0;
      cal_press_high <= '0;
      cal_mixed      <= '0;
      cal_hum        <= '0;
    end else if (wr_en) begin
      case (wr_index)
        pthc_pkg::REG_CAL_TEMP:       cal_temp       <= wr_data[47:0];
        pthc_pkg::REG_CAL_PRESS_LOW:  cal_press_low  <= wr_data;
        pthc_pkg::REG_CAL_PRESS_HIGH: cal_press_high <= wr_data;
        pthc_pkg::REG_CAL_MIXED:      cal_mixed      <= wr_data[47:0];
        pthc_pkg::REG_CAL_HUM:        cal_hum        <= wr_data[39:0];
        default: ;
      endcase
    end
  end

  // Unpack the coefficients from the packed registers.
  always_comb begin
    coef.t1 = pthc_pkg::zext16(cal_temp[15:0]);
    coef.t2 = pthc_pkg::sext16(cal_temp[31:16]);
    coef.t3 = pthc_pkg::sext16(cal_temp[47:32]);
    coef.p1 = pthc_pkg::zext16(cal_press_low[15:0]);
    coef.p2 = pthc_pkg::sext16(cal_press_low[31:16]);
    coef.p3 = pthc_pkg::sext16(cal_press_low[47:32]);
    coef.p4 = pthc_pkg::sext16(cal_press_low[63:48]);
    coef.p5 = pthc_pkg::sext16(cal_press_high[15:0]);
    coef.p6 = pthc_pkg::sext16(cal_press_high[31:16]);
    coef.p7 = pthc_pkg::sext16(cal_press_high[47:32]);
    coef.p8 = pthc_pkg::sext16(cal_press_high[63:48]);
    coef.p9 = pthc_pkg::sext16(cal_mixed[15:0]);
    coef.h1 = pthc_pkg::zext8(cal_mixed[23:16]);
    coef.h2 = pthc_pkg::sext16(cal_mixed[39:24]);
    coef.h3 = pthc_pkg::zext8(cal_mixed[47:40]);
    coef.h4 = pthc_pkg::sext16(cal_hum[15:0]);
    coef.h5 = pthc_pkg::sext16(cal_hum[31:16]);
    coef.h6 = pthc_pkg::sext8(cal_hum[39:32]);
  end

  pthc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .raw_p     (raw_pressure),
    .raw_t     (raw_temperature),
    .raw_h     (raw_humidity),
    .c         (coef),
    .out_valid (f_valid),
    .dividend  (f_dvd),
    .divisor   (f_den),
    .side      (f_side)
  );

  pthc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .dividend  (f_dvd),
    .divisor   (f_den),
    .in_side   (f_side),
    .out_valid (d_valid),
    .quotient  (d_quo),
    .out_side  (d_side)
  );

  pthc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (d_valid),
    .quotient          (d_quo),
    .in_side           (d_side),
    .c                 (coef),
    .done              (done),
    .temperature_centi (temperature_centi),
    .pressure_pa       (pressure_pa),
    .humidity_q10      (humidity_q10),
    .pressure_invalid  (pressure_invalid)
  );

  // Checks on the pipeline as a whole.
  `PTHC_ASSERT_IMP(a_done_latency, done, $past(start, pthc_pkg::LATENCY))
  `PTHC_ASSERT_IMP(a_invalid_zero, done && pressure_invalid, pressure_pa == '0)
  `PTHC_ASSERT_NEVER(a_hum_range, done && (humidity_q10 > 17'd102400))

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the pressure, temperature and humidity compensation block.
// Holds its own 32-bit wrapping predictor and checks every done strobe against it.
// Depends on pthc_pkg and pth_sensor_compensation.
module testbench;

  localparam int CYCLE_LIMIT = 400000;

  // Compensated reading as the block should deliver it.
  typedef struct {
    logic [31:0] temp;
    logic [31:0] press;
    logic [16:0] hum;
    logic        inv;
  } compensated_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [19:0]        raw_pressure;
  logic [19:0]        raw_temperature;
  logic [15:0]        raw_humidity;
  logic               wr_en;
  logic [2:0]         wr_index;
  logic [63:0]        wr_data;
  logic               done;
  logic signed [31:0] temperature_centi;
  logic [31:0]        pressure_pa;
  logic [16:0]        humidity_q10;
  logic               pressure_invalid;

  // Shadow copy of the calibration registers.
  logic [47:0] cal_t;
  logic [63:0] cal_pl;
  logic [63:0] cal_ph;
  logic [47:0] cal_m;
  logic [39:0] cal_h;

  compensated_t pending_readings[$];
  int           error_count;
  int           cycle_count;
  bit           no_idle;

  // Typical factory calibration, packed as the registers expect.
  localparam logic [47:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_PL = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TYP_PH = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [47:0] TYP_M  = {8'd0, 16'd362, 8'd75, 16'd6000};
  localparam logic [39:0] TYP_H  = {8'd30, 16'd0, 16'd324};

  pth_sensor_compensation i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .raw_pressure(raw_pressure), .raw_temperature(raw_temperature),
    .raw_humidity(raw_humidity), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data), .done(done), .temperature_centi(temperature_centi),
    .pressure_pa(pressure_pa), .humidity_q10(humidity_q10),
    .pressure_invalid(pressure_invalid)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] sra32(logic [31:0] x, int n);
    logic signed [31:0] s;
    s = $signed(x) >>> n;
    return s;
  endfunction

  function automatic logic [31:0] widen16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Works out the compensated reading from the raw values and shadow calibration.
  function automatic compensated_t compensate(logic [19:0] rp, logic [19:0] rt,
                                              logic [15:0] rh);
    compensated_t r;
    logic [31:0] adc_p, adc_t, adc_h;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] v1, v2, d, tf, sq, p, x, a, b, c, e, f, q;
    adc_p = {12'd0, rp};
    adc_t = {12'd0, rt};
    adc_h = {16'd0, rh};
    t1 = {16'd0, cal_t[15:0]};
    t2 = widen16(cal_t[31:16]);
    t3 = widen16(cal_t[47:32]);
    p1 = {16'd0, cal_pl[15:0]};
    p2 = widen16(cal_pl[31:16]);
    p3 = widen16(cal_pl[47:32]);
    p4 = widen16(cal_pl[63:48]);
    p5 = widen16(cal_ph[15:0]);
    p6 = widen16(cal_ph[31:16]);
    p7 = widen16(cal_ph[47:32]);
    p8 = widen16(cal_ph[63:48]);
    p9 = widen16(cal_m[15:0]);
    h1 = {24'd0, cal_m[23:16]};
    h2 = widen16(cal_m[39:24]);
    h3 = {24'd0, cal_m[47:40]};
    h4 = widen16(cal_h[15:0]);
    h5 = widen16(cal_h[31:16]);
    h6 = {{24{cal_h[39]}}, cal_h[39:32]};
    r.inv = 1'b0;

    // Temperature, whose fine value feeds the other two.
    v1 = sra32(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    v2 = sra32(sra32(d * d, 12) * t3, 14);
    tf = v1 + v2;
    r.temp = sra32(tf * 32'd5 + 32'd128, 8);

    // Pressure, with the divisor checked for zero.
    v1 = sra32(tf, 1) - 32'd64000;
    q = sra32(v1, 2);
    sq = q * q;
    v2 = sra32(sq, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = sra32(v2, 2) + (p4 << 16);
    v1 = sra32(sra32(p3 * sra32(sq, 13), 3) + sra32(p2 * v1, 1), 18);
    v1 = sra32((32'd32768 + v1) * p1, 15);
    if (v1 == 32'd0) begin
      p = 32'd0;
      r.inv = 1'b1;
    end else begin
      p = ((32'd1048576 - adc_p) - sra32(v2, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / v1;
      else p = (p / v1) * 32'd2;
      v1 = sra32(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      v2 = sra32((p >> 2) * p8, 13);
      p = p + sra32(v1 + v2 + p7, 4);
    end
    r.press = p;

    // Humidity, clamped before the final scaling.
    x = tf - 32'd76800;
    a = (adc_h << 14) - (h4 << 20) - h5 * x;
    a = sra32(a + 32'd16384, 15);
    b = sra32(x * h6, 10);
    c = sra32(x * h3, 11) + 32'd32768;
    e = sra32(b * c, 10) + 32'd2097152;
    f = sra32(e * h2 + 32'd8192, 14);
    x = a * f;
    x = x - sra32(sra32(sra32(x, 15) * sra32(x, 15), 7) * h1, 4);
    if (x[31]) x = 32'd0;
    if (x > 32'd419430400) x = 32'd419430400;
    r.hum = x[28:12];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  // Compares each result transaction with the oldest expected reading.
  always @(posedge clk) begin
    compensated_t w;
    if (!rst && done) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("result transaction with no reading outstanding",
                        {31'd0, done}, 32'd0);
      end else begin
        w = pending_readings.pop_front();
        if (temperature_centi !== w.temp)
          report_mismatch("temperature", temperature_centi, w.temp);
        if (pressure_pa !== w.press)
          report_mismatch("pressure", pressure_pa, w.press);
        if (humidity_q10 !== w.hum)
          report_mismatch("humidity", {15'd0, humidity_q10}, {15'd0, w.hum});
        if (pressure_invalid !== w.inv)
          report_mismatch("pressure invalid flag", {31'd0, pressure_invalid},
                          {31'd0, w.inv});
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** pth_sensor_compensation: FAILED **");
      $finish;
    end
  end

  // Sends one reading transaction after a random gap, or with no gap while no_idle is set.
  task automatic send_reading(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
    int gap;
    gap = 0;
    if (!no_idle) begin
      if ($urandom_range(0, 9) < 6) gap = 0;
      else if ($urandom_range(0, 9) < 8) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    raw_pressure <= rp;
    raw_temperature <= rt;
    raw_humidity <= rh;
    do @(posedge clk); while (busy);
    pending_readings.push_back(compensate(rp, rt, rh));
  endtask

  // Lowers start and waits until every reading has come back and the pipeline is empty.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (pthc_pkg::LATENCY + 8) @(posedge clk);
  endtask

  // Writes all five calibration registers back to back; only while idle.
  task automatic write_calibration(logic [47:0] t, logic [63:0] pl, logic [63:0] ph,
                                   logic [47:0] m, logic [39:0] h);
    logic [63:0] vals[5];
    logic [2:0]  idx[5];
    vals = '{{16'hDEAD, t}, pl, ph, {16'hBEEF, m}, {24'hC0FFEE, h}};
    idx = '{pthc_pkg::REG_CAL_TEMP, pthc_pkg::REG_CAL_PRESS_LOW,
            pthc_pkg::REG_CAL_PRESS_HIGH, pthc_pkg::REG_CAL_MIXED,
            pthc_pkg::REG_CAL_HUM};
    for (int i = 0; i < 5; i++) begin
      wr_en <= 1'b1;
      wr_index <= idx[i];
      wr_data <= vals[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
    cal_t = t;
    cal_pl = pl;
    cal_ph = ph;
    cal_m = m;
    cal_h = h;
    @(posedge clk);
  endtask

  function automatic logic [19:0] realistic20(logic [19:0] centre);
    return centre - 20'd150000 + 20'($urandom_range(0, 300000));
  endfunction

  // All-zero calibration after reset gives a zero divisor.
  task automatic test_unprogrammed;
    send_reading(20'd0, 20'd0, 16'd0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_reading(20'd415148, 20'd519888, 16'd30000);
    drain();
  endtask

  // Typical calibration with the raw fields at their extremes.
  task automatic test_raw_extremes;
    logic [19:0] ext20[3];
    logic [15:0] ext16[3];
    ext20 = '{20'd0, 20'hFFFFF, 20'h80000};
    ext16 = '{16'd0, 16'hFFFF, 16'h8000};
    write_calibration(TYP_T, TYP_PL, TYP_PH, TYP_M, TYP_H);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        send_reading(ext20[i], ext20[j], ext16[(i + j) % 3]);
    send_reading(20'd415148, 20'd519888, 16'd30000);
    drain();
  endtask

  // Writes to indexes past the last register must leave the calibration alone.
  task automatic test_unused_index;
    for (int i = int'(pthc_pkg::REG_CAL_HUM) + 1; i < 8; i++) begin
      wr_en <= 1'b1;
      wr_index <= 3'(i);
      wr_data <= {$urandom, $urandom};
      @(posedge clk);
    end
    wr_en <= 1'b0;
    @(posedge clk);
    send_reading(20'd415148, 20'd519888, 16'd30000);
    send_reading(20'd300000, 20'd600000, 16'd50000);
    drain();
  endtask

  // Calibration at its bit extremes.
  task automatic test_calibration_extremes;
    write_calibration('1, '1, '1, '1, '1);
    send_reading(20'd415148, 20'd519888, 16'd30000);
    send_reading(20'hFFFFF, 20'd0, 16'hFFFF);
    drain();
    write_calibration({3{16'h8000}}, {4{16'h8000}}, {4{16'h7FFF}},
                      {8'hFF, 16'h8000, 8'hFF, 16'h7FFF}, {8'h80, 16'h7FFF, 16'h8000});
    send_reading(20'd415148, 20'd519888, 16'd30000);
    send_reading(20'd0, 20'hFFFFF, 16'd0);
    drain();
  endtask

  // Near-typical calibration with realistic readings and some full-range noise.
  task automatic test_random_typical(int count);
    logic [63:0] jit;
    for (int ph = 0; ph < 3; ph++) begin
      jit = {$urandom, $urandom} & 64'h003F_003F_003F_003F;
      write_calibration(TYP_T ^ jit[47:0], TYP_PL ^ jit, TYP_PH ^ jit,
                        TYP_M ^ {8'h03, jit[39:0] & 40'h003F_03_003F},
                        TYP_H ^ {8'h03, jit[31:0]});
      no_idle = (ph == 1);
      for (int n = 0; n < count / 3; n++) begin
        if (ph == 2 && n == count / 6) begin
          // The sender holds off until the pipeline has emptied.
          drain();
        end
        if ($urandom_range(0, 4) == 0)
          send_reading(20'($urandom), 20'($urandom), 16'($urandom));
        else
          send_reading(realistic20(20'd415148), realistic20(20'd519888),
                       16'($urandom_range(10000, 55000)));
      end
      drain();
    end
    no_idle = 1'b0;
  endtask

  // Fully random calibration over several phases.
  task automatic test_random_calibration(int phases, int count);
    for (int ph = 0; ph < phases; ph++) begin
      write_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                        {$urandom, $urandom}, 48'({$urandom, $urandom}),
                        40'({$urandom, $urandom}));
      for (int n = 0; n < count; n++)
        send_reading(20'($urandom), 20'($urandom), 16'($urandom));
      drain();
    end
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    cal_t = '0;
    cal_pl = '0;
    cal_ph = '0;
    cal_m = '0;
    cal_h = '0;
    rst <= 1'b1;
    start <= 1'b0;
    raw_pressure <= '0;
    raw_temperature <= '0;
    raw_humidity <= '0;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unprogrammed();
    test_raw_extremes();
    test_unused_index();
    test_calibration_extremes();
    test_random_typical(600);
    test_random_calibration(10, 55);

    if (error_count == 0) begin
      $display("** pth_sensor_compensation: PASSED **");
    end else begin
      $display("** pth_sensor_compensation: FAILED **");
    end
    $finish;
  end

endmodule
